// ===== hw/rtl/tcae_pkg.sv =====
// Shared constants and types for the torus cellular automaton engine.
package tcae_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    localparam int CMD_W      = 3;
    localparam int COL_IN_W   = 6;
    localparam int ROW_IN_W   = 6;
    localparam int RULE_WORDS = 8;
    localparam int RULE_IDX_W = 3;
    localparam int RULE_W     = 64;
    localparam int COUNT_W    = 13;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int RESET_SIZE = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RULE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED = 2'd2;

    // 512-entry rule table, word index selects the upper three index bits
    typedef logic [RULE_WORDS-1:0][RULE_W-1:0] t_rule;

endpackage

// ===== hw/rtl/tcae_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tcae_ram
    import tcae_pkg::*;
#(
    parameter int WIDTH = RULE_W,
    parameter int DEPTH = MAX_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcae_row_calc.sv =====
// One row of next-generation cells from three current rows and the rule table.
module tcae_row_calc
    import tcae_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic [MAX_COLS-1:0]              i_up,
    input  logic [MAX_COLS-1:0]              i_mid,
    input  logic [MAX_COLS-1:0]              i_down,
    input  logic [$clog2(MAX_COLS+1)-1:0]    i_cols,
    input  t_rule                            i_rule,
    output logic [MAX_COLS-1:0]              o_row
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [COL_W-1:0] last_col;
    logic [2:0]       wrap_left;   // column w-1, left neighbor of column 0
    logic [2:0]       wrap_right;  // column 0, right neighbor of column w-1

    assign last_col   = COL_W'(i_cols - 1'b1);
    assign wrap_left  = {i_up[last_col], i_mid[last_col], i_down[last_col]};
    assign wrap_right = {i_up[0], i_mid[0], i_down[0]};

    for (genvar x = 0; x < MAX_COLS; x++) begin : g_cell
        logic [2:0] lc;
        logic [2:0] oc;
        logic [2:0] rc;
        logic [8:0] idx;

        assign oc = {i_up[x], i_mid[x], i_down[x]};

        if (x == 0) begin : g_first
            assign lc = wrap_left;
        end else begin : g_left
            assign lc = {i_up[x-1], i_mid[x-1], i_down[x-1]};
        end

        if (x == MAX_COLS - 1) begin : g_last
            assign rc = wrap_right;
        end else begin : g_right
            assign rc = (COL_W'(x) == last_col) ? wrap_right
                                                : {i_up[x+1], i_mid[x+1], i_down[x+1]};
        end

        assign idx      = {lc, oc, rc};
        assign o_row[x] = i_rule[idx[8:6]][idx[5:0]];
    end

endmodule

// ===== hw/rtl/torus_cellular_automaton_engine_unit.sv =====
// Top level: torus cellular automaton engine with row-wide plane memories.
//
//  channel   signals                                    handshake
//  --------  -----------------------------------------  ------------------------
//  command   i_command i_col i_row i_cell_value          start & !busy
//            i_rule_word_index i_rule_word_bits
//  result    o_read_value o_alive_count                  o_strobe, one cycle
//  config    i_cfg_idx i_cfg_data                        i_cfg_we
//
// A step runs a copy pass (plus a rule pass when not paused) over the h rows
// in use; each pass moves one row word per cycle through the plane memories.
// Erase clears every row; read and write of a cell pass through a cell state,
// rule load and unknown commands complete from idle. After reset a clearing
// pass runs with busy high. Results carry no backpressure; one word per command.
module torus_cellular_automaton_engine_unit
    import tcae_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [COL_IN_W-1:0]    i_col,
    input  logic [ROW_IN_W-1:0]    i_row,
    input  logic                   i_cell_value,
    input  logic [RULE_IDX_W-1:0]  i_rule_word_index,
    input  logic [RULE_W-1:0]      i_rule_word_bits,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic                   o_read_value,
    output logic [COUNT_W-1:0]     o_alive_count
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int SZC_W = $clog2(MAX_COLS + 1);
    localparam int SZR_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_W = $clog2(MAX_ROWS + 3);
    localparam int CMP_W = 10;
    localparam int POP_P = 1 << COL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_COPY  = 6'b000100,
        S_CALC  = 6'b001000,
        S_CELL  = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    function automatic logic [SZC_W-1:0] clamp_cols(logic [SIZE_W-1:0] v);
        if (v < SIZE_W'(2)) begin
            return SZC_W'(2);
        end else if (CMP_W'(v) > CMP_W'(MAX_COLS)) begin
            return SZC_W'(MAX_COLS);
        end
        return SZC_W'(v);
    endfunction

    function automatic logic [SZR_W-1:0] clamp_rows(logic [SIZE_W-1:0] v);
        if (v < SIZE_W'(2)) begin
            return SZR_W'(2);
        end else if (CMP_W'(v) > CMP_W'(MAX_ROWS)) begin
            return SZR_W'(MAX_ROWS);
        end
        return SZR_W'(v);
    endfunction

    // configuration
    logic [SZC_W-1:0] r_cols, n_cols;
    logic [SZR_W-1:0] r_rows, n_rows;
    logic             r_paused, n_paused;

    // control
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_report, n_report;
    t_rule                r_rule, n_rule;
    logic                 r_strobe, n_strobe;
    logic                 r_read_value, n_read_value;
    logic [COUNT_W-1:0]   r_alive_count, n_alive_count;

    // payload
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [COL_IN_W-1:0]  r_col, n_col;
    logic [ROW_IN_W-1:0]  r_row, n_row;
    logic                 r_cell_value, n_cell_value;
    logic [COUNT_W-1:0]   r_acc, n_acc;
    logic [SZC_W-1:0]     r_pop, n_pop;
    logic [MAX_COLS-1:0]  r_up, n_up;
    logic [MAX_COLS-1:0]  r_mid, n_mid;

    // memory ports
    logic                 cur_we, nxt_we;
    logic [ROW_W-1:0]     cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
    logic [MAX_COLS-1:0]  cur_wdata, nxt_wdata, cur_rd, nxt_rd;

    logic [MAX_COLS-1:0]  col_mask;
    logic [MAX_COLS-1:0]  calc_row;
    logic [MAX_COLS-1:0]  cur_cell_row, nxt_cell_row;
    logic [CNT_W-1:0]     h_cnt;
    logic [ROW_W-1:0]     last_row;
    logic [COL_W-1:0]     col_addr;
    logic [ROW_W-1:0]     row_addr;
    logic                 in_grid;
    logic [COUNT_W:0]     acc_sum;
    logic [SZC_W-1:0]     pop_tree [COL_W+1][POP_P];
    logic [SZC_W-1:0]     pop_out;
    logic                 accept;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign h_cnt    = CNT_W'(r_rows);
    assign last_row = ROW_W'(r_rows - 1'b1);
    assign col_addr = COL_W'(r_col);
    assign row_addr = ROW_W'(r_row);
    assign in_grid  = (CMP_W'(r_col) < CMP_W'(r_cols)) && (CMP_W'(r_row) < CMP_W'(r_rows));
    assign acc_sum  = {1'b0, r_acc} + (COUNT_W+1)'(r_pop);

    always_comb begin
        for (int x = 0; x < MAX_COLS; x++) begin
            col_mask[x] = (CMP_W'(x) < CMP_W'(r_cols));
        end
    end

    // population count of the committed row, pairwise adder tree
    always_comb begin
        pop_tree = '{default: '0};
        for (int i = 0; i < MAX_COLS; i++) begin
            pop_tree[0][i] = SZC_W'(nxt_rd[i] & col_mask[i]);
        end
        for (int l = 0; l < COL_W; l++) begin
            for (int i = 0; i < POP_P / 2; i++) begin
                if (i < (POP_P >> (l + 1))) begin
                    pop_tree[l+1][i] = pop_tree[l][2*i] + pop_tree[l][2*i+1];
                end
            end
        end
        pop_out = pop_tree[COL_W][0];
    end

    always_comb begin
        cur_cell_row           = cur_rd;
        cur_cell_row[col_addr] = r_cell_value;
        nxt_cell_row           = nxt_rd;
        nxt_cell_row[col_addr] = r_cell_value;
    end

    tcae_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_cur_plane (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rd)
    );

    tcae_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_nxt_plane (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rd)
    );

    tcae_row_calc #(
        .MAX_COLS (MAX_COLS)
    ) u_row_calc (
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_down (cur_rd),
        .i_cols (r_cols),
        .i_rule (r_rule),
        .o_row  (calc_row)
    );

    always_comb begin
        n_cols   = r_cols;
        n_rows   = r_rows;
        n_paused = r_paused;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  n_cols   = clamp_cols(SIZE_W'(i_cfg_data));
                CFG_HEIGHT: n_rows   = clamp_rows(SIZE_W'(i_cfg_data));
                CFG_PAUSED: n_paused = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_report      = r_report;
        n_rule        = r_rule;
        n_strobe      = 1'b0;
        n_read_value  = 1'b0;
        n_alive_count = '0;
        n_cmd         = r_cmd;
        n_col         = r_col;
        n_row         = r_row;
        n_cell_value  = r_cell_value;
        n_acc         = r_acc;
        n_pop         = r_pop;
        n_up          = r_up;
        n_mid         = r_mid;

        cur_we    = 1'b0;
        nxt_we    = 1'b0;
        cur_waddr = '0;
        nxt_waddr = '0;
        cur_wdata = '0;
        nxt_wdata = '0;
        cur_raddr = ROW_W'(i_row);
        nxt_raddr = ROW_W'(i_row);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd        = i_command;
                    n_col        = i_col;
                    n_row        = i_row;
                    n_cell_value = i_cell_value;
                    n_cnt        = '0;
                    unique case (i_command)
                        CMD_STEP: begin
                            n_state = S_COPY;
                            n_acc   = '0;
                        end
                        CMD_ERASE: begin
                            n_state  = S_CLEAR;
                            n_report = 1'b1;
                        end
                        CMD_READ, CMD_WRITE: begin
                            n_state = S_CELL;
                        end
                        CMD_RULE: begin
                            n_rule[i_rule_word_index] = i_rule_word_bits;
                            n_strobe                  = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                cur_we    = 1'b1;
                nxt_we    = 1'b1;
                cur_waddr = ROW_W'(r_cnt);
                nxt_waddr = ROW_W'(r_cnt);
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAX_ROWS - 1)) begin
                    n_state  = S_IDLE;
                    n_strobe = r_report;
                end
            end

            S_CELL: begin
                // row words were read at accept
                if (r_cmd == CMD_READ) begin
                    n_read_value = in_grid & cur_rd[col_addr];
                end else if (in_grid) begin
                    cur_we    = 1'b1;
                    nxt_we    = 1'b1;
                    cur_waddr = row_addr;
                    nxt_waddr = row_addr;
                    cur_wdata = cur_cell_row;
                    nxt_wdata = nxt_cell_row;
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_COPY: begin
                // read row cnt, commit row cnt-1, accumulate row cnt-2
                cur_raddr = ROW_W'(r_cnt);
                nxt_raddr = ROW_W'(r_cnt);
                if (r_cnt >= CNT_W'(1) && r_cnt <= h_cnt) begin
                    cur_we    = 1'b1;
                    cur_waddr = ROW_W'(r_cnt - 1'b1);
                    cur_wdata = (nxt_rd & col_mask) | (cur_rd & ~col_mask);
                    n_pop     = pop_out;
                end
                if (r_cnt >= CNT_W'(2) && r_cnt <= h_cnt + CNT_W'(1)) begin
                    n_acc = (acc_sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX
                                                                : acc_sum[COUNT_W-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == h_cnt + CNT_W'(2)) begin
                    n_cnt = '0;
                    if (r_paused) begin
                        n_state       = S_IDLE;
                        n_strobe      = 1'b1;
                        n_alive_count = r_acc;
                    end else begin
                        n_state = S_CALC;
                    end
                end
            end

            S_CALC: begin
                // current rows read in order h-1, 0 .. h-1, 0; row cnt-3 is
                // centered when its lower neighbor arrives
                if (r_cnt == '0) begin
                    cur_raddr = last_row;
                end else if (r_cnt <= h_cnt) begin
                    cur_raddr = ROW_W'(r_cnt - 1'b1);
                end else begin
                    cur_raddr = '0;
                end
                nxt_raddr = ROW_W'(r_cnt - CNT_W'(2));
                if (r_cnt >= CNT_W'(1)) begin
                    n_up  = r_mid;
                    n_mid = cur_rd;
                end
                if (r_cnt >= CNT_W'(3)) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = ROW_W'(r_cnt - CNT_W'(3));
                    nxt_wdata = (calc_row & col_mask) | (nxt_rd & ~col_mask);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == h_cnt + CNT_W'(2)) begin
                    n_cnt         = '0;
                    n_state       = S_IDLE;
                    n_strobe      = 1'b1;
                    n_alive_count = r_acc;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols        <= clamp_cols(SIZE_W'(RESET_SIZE));
            r_rows        <= clamp_rows(SIZE_W'(RESET_SIZE));
            r_paused      <= 1'b1;
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_report      <= 1'b0;
            r_rule        <= '0;
            r_strobe      <= 1'b0;
            r_read_value  <= 1'b0;
            r_alive_count <= '0;
        end else begin
            r_cols        <= n_cols;
            r_rows        <= n_rows;
            r_paused      <= n_paused;
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_report      <= n_report;
            r_rule        <= n_rule;
            r_strobe      <= n_strobe;
            r_read_value  <= n_read_value;
            r_alive_count <= n_alive_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_col        <= n_col;
        r_row        <= n_row;
        r_cell_value <= n_cell_value;
        r_acc        <= n_acc;
        r_pop        <= n_pop;
        r_up         <= n_up;
        r_mid        <= n_mid;
    end

    assign o_strobe      = r_strobe;
    assign o_read_value  = r_read_value;
    assign o_alive_count = r_alive_count;

endmodule
